// ----- rtl/fspp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the fading sprite particle pool.
// Used by the controller, the datapath and the top level; depends on nothing.
package fspp_pkg;

  // Default pool size.
  localparam int POOL_SLOTS_DEF = 16;

  // Field widths.
  localparam int COORD_W = 16;
  localparam int LIFE_W  = 10;
  localparam int ANG_W   = 10;
  localparam int RAD_W   = 20;
  localparam int ALPHA_W = 8;
  localparam int CFG_W   = 12;
  localparam int SLOT_W  = 4;

  // Stream word widths.
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 144;

  // Corner coordinates per quad: four corners, x and y each.
  localparam int CORNER_N = 8;

  // Sequencer counter and last step of each multi-cycle phase.
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(RAD_W - 1);
  localparam logic [CNT_W-1:0] TRIG_LAST = CNT_W'(10);
  localparam logic [CNT_W-1:0] CORN_LAST = CNT_W'(CORNER_N - 1);

  localparam logic [CFG_W-1:0]   RADIUS_RST = CFG_W'(256);
  localparam logic [ALPHA_W-1:0] ALPHA_FULL = ALPHA_W'(255);

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_ACCEPT = 3'd1,
    OP_DIV    = 3'd2,
    OP_SPAWN  = 3'd3,
    OP_UPDATE = 3'd4,
    OP_TRIG   = 3'd5,
    OP_CORNER = 3'd6,
    OP_MOVE   = 3'd7
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [CNT_W-1:0] step;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic cur_used;
    logic live;
  } dp_stat_t;

  // One stored particle.
  typedef struct packed {
    logic [LIFE_W-1:0]         life;
    logic [RAD_W-1:0]          radius;
    logic [RAD_W-1:0]          rstep;
    logic [ALPHA_W-1:0]        alpha;
    logic [ALPHA_W-1:0]        astep;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [ANG_W-1:0]          angle;
  } slot_rec_t;

  // Quarter-wave argument: z = q * 64 with q folded into 0..256.
  function automatic logic [14:0] quarter_z(input logic [ANG_W-1:0] a);
    logic [8:0] qq;
    qq = a[8] ? (9'd256 - {1'b0, a[7:0]}) : {1'b0, a[7:0]};
    return {qq, 6'b0};
  endfunction

endpackage

// ----- rtl/fading_sprite_particle_pool_top.sv -----
`timescale 1ns / 1ps
// Fading sprite particle pool: a fixed pool of rotating, shrinking sprites.
//
// Input stream (s_*): one word per command. tuser selects spawn (0) or tick (1).
// A spawn claims the lowest free slot and answers with one word: slot number,
// accepted flag in m_tuser (0 when the pool is full), tlast high.
// A tick ages every used slot in order, frees expired ones and emits one quad
// word per slot still live; tlast marks the final quad. A tick that leaves no
// live slot produces no word.
// A spawn runs the bit-serial divider that forms the per-tick steps, then stores
// the slot. A tick reads each slot in order; for each live slot it runs the shared
// multiplier that forms sine, cosine and the rotated offsets, then forms one corner
// coordinate per cycle.
// The block takes one word at a time; s_tready is low while it is busy.
// A finished word sits in the output register; when the receiver stalls the
// block holds one further quad and then waits until m_tready frees the register.
// Reset empties the pool and sets initial_radius to 256. The radius register
// (cfg_we/cfg_wdata) may be written only while the block is idle.
module fading_sprite_particle_pool_top import fspp_pkg::*; #(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // tdata: pos_x[15:0], pos_y[31:16], life[41:32], angle[51:42], zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // tuser: mode
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // tdata: slot[3:0], corner0_x, corner0_y, corner1_x, corner1_y, corner2_x,
  // corner2_y, corner3_x, corner3_y (16 bits each from bit 4), fade_alpha[139:132]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // tuser: accepted
  output logic                  m_tuser,
  output logic                  m_tlast
);

  localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [IDX_W-1:0] cmd_idx;

  // Sequencer.
  fspp_ctrl #(
    .POOL_SLOTS(POOL_SLOTS),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .stat    (stat),
    .cmd     (cmd),
    .cmd_idx (cmd_idx)
  );

  // Slot store and arithmetic.
  fspp_dp #(
    .POOL_SLOTS(POOL_SLOTS),
    .IDX_W     (IDX_W)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_data  (s_tdata),
    .cmd      (cmd),
    .cmd_idx  (cmd_idx),
    .stat     (stat),
    .out_data (m_tdata),
    .out_acc  (m_tuser),
    .out_last (m_tlast)
  );

endmodule

// ----- rtl/fspp_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module fspp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/fspp_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the particle pool: slot store, divider, shared multiplier,
// corner math and result registers. Depends on fspp_pkg and fspp_ram.
module fspp_dp import fspp_pkg::*; #(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF,
  parameter int IDX_W      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  dp_cmd_t               cmd,
  input  logic [IDX_W-1:0]      cmd_idx,
  output dp_stat_t              stat,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_acc,
  output logic                  out_last
);

  localparam int REC_W = $bits(slot_rec_t);

  logic [CFG_W-1:0]   init_radius;
  logic               used [POOL_SLOTS];
  logic [IDX_W-1:0]   free_idx;
  logic               full;

  logic signed [COORD_W-1:0] in_cx, in_cy;
  logic [ANG_W-1:0]          in_ang;
  logic [RAD_W-1:0]          spawn_rad;

  logic [LIFE_W-1:0] div_d;
  logic [RAD_W-1:0]  div_qr, div_qa;
  logic [LIFE_W-1:0] rem_r, rem_a;
  logic [LIFE_W:0]   tr_r, tr_a;
  logic              ge_r, ge_a;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  slot_rec_t         ram_wrec, rd, upd;

  logic [RAD_W-1:0]          w_rad;
  logic [ALPHA_W-1:0]        w_alpha;
  logic signed [COORD_W-1:0] w_cx, w_cy;
  logic [ANG_W-1:0]          w_ang;

  logic [ANG_W-1:0]   ang_c;
  logic [14:0]        zs, zc, z2;
  logic signed [20:0] mul_a;
  logic signed [16:0] mul_b, sin_v, s_now;
  logic signed [37:0] prod, acc_a, acc_b;
  logic [16:0]        p14, p15;

  logic [2:0]          ck;
  logic signed [37:0]  pa, pb, qa, qb, v, rnd;
  logic signed [17:0]  tot;
  logic signed [15:0]  ctr, sat_v;

  logic [SLOT_W-1:0]         pend_slot, out_slot;
  logic                      pend_acc;
  logic [ALPHA_W-1:0]        pend_alpha, out_alpha;
  logic signed [COORD_W-1:0] pend_c [CORNER_N];
  logic signed [COORD_W-1:0] out_c  [CORNER_N];

  // Radius register.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_radius <= RADIUS_RST;
    end else if (cfg_we) begin
      init_radius <= cfg_wdata;
    end
  end

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    full     = 1'b1;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_idx = IDX_W'(i);
        full     = 1'b0;
      end
    end
  end

  // Slot store.
  assign ram_we    = (cmd.op == OP_SPAWN && !full) || (cmd.op == OP_UPDATE);
  assign ram_waddr = (cmd.op == OP_SPAWN) ? free_idx : cmd_idx;

  always_comb begin
    if (cmd.op == OP_SPAWN) begin
      ram_wrec.life   = div_d;
      ram_wrec.radius = spawn_rad;
      ram_wrec.rstep  = div_qr;
      ram_wrec.alpha  = ALPHA_FULL;
      ram_wrec.astep  = div_qa[ALPHA_W-1:0];
      ram_wrec.cx     = in_cx;
      ram_wrec.cy     = in_cy;
      ram_wrec.angle  = in_ang;
    end else begin
      ram_wrec = upd;
    end
  end

  fspp_ram #(
    .WIDTH (REC_W),
    .DEPTH (POOL_SLOTS),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wrec),
    .raddr(cmd_idx),
    .rdata(rd)
  );

  // Aging of the slot just read.
  always_comb begin
    upd        = rd;
    upd.life   = rd.life - 1'b1;
    upd.radius = (rd.radius > rd.rstep) ? (rd.radius - rd.rstep) : '0;
    upd.alpha  = (rd.alpha > rd.astep) ? (rd.alpha - rd.astep) : '0;
  end

  assign stat.cur_used = used[cmd_idx];
  assign stat.live     = (upd.life != '0);

  // Used flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
        used[i] <= 1'b0;
      end
    end else if (cmd.op == OP_SPAWN && !full) begin
      used[free_idx] <= 1'b1;
    end else if (cmd.op == OP_UPDATE && !stat.live) begin
      used[cmd_idx] <= 1'b0;
    end
  end

  // Restoring divider step for both quotients.
  assign tr_r = {rem_r, div_qr[RAD_W-1]};
  assign tr_a = {rem_a, div_qa[RAD_W-1]};
  assign ge_r = (tr_r >= {1'b0, div_d});
  assign ge_a = (tr_a >= {1'b0, div_d});

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCEPT) begin
      in_cx     <= in_data[15:0];
      in_cy     <= in_data[31:16];
      in_ang    <= in_data[51:42];
      div_d     <= (in_data[41:32] == '0) ? LIFE_W'(1) : in_data[41:32];
      spawn_rad <= {init_radius, 8'b0};
      div_qr    <= {init_radius, 8'b0};
      div_qa    <= RAD_W'(ALPHA_FULL);
      rem_r     <= '0;
      rem_a     <= '0;
    end else if (cmd.op == OP_DIV) begin
      rem_r  <= ge_r ? LIFE_W'(tr_r - {1'b0, div_d}) : tr_r[LIFE_W-1:0];
      rem_a  <= ge_a ? LIFE_W'(tr_a - {1'b0, div_d}) : tr_a[LIFE_W-1:0];
      div_qr <= {div_qr[RAD_W-2:0], ge_r};
      div_qa <= {div_qa[RAD_W-2:0], ge_a};
    end
  end

  // Working copy of the slot being drawn.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_UPDATE) begin
      w_rad   <= upd.radius;
      w_alpha <= upd.alpha;
      w_cx    <= upd.cx;
      w_cy    <= upd.cy;
      w_ang   <= upd.angle;
    end
  end

  // Shared multiplier: sine, cosine, then radius times both.
  assign ang_c = w_ang + ANG_W'(256);
  assign zs    = quarter_z(w_ang);
  assign zc    = quarter_z(ang_c);
  assign p14   = prod[30:14];
  assign p15   = prod[31:15];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    s_now = w_ang[9] ? -$signed(p15) : $signed(p15);
    case (cmd.step)
      5'd0: begin mul_a = 21'(zs); mul_b = 17'(zs); end
      5'd1: begin mul_a = 21'(p14); mul_b = 17'sd2320; end
      5'd2: begin mul_a = 21'(z2); mul_b = 17'sd21024 - $signed(p14); end
      5'd3: begin mul_a = 21'(zs); mul_b = 17'sd51472 - $signed(p14); end
      5'd4: begin mul_a = 21'(zc); mul_b = 17'(zc); end
      5'd5: begin mul_a = 21'(p14); mul_b = 17'sd2320; end
      5'd6: begin mul_a = 21'(z2); mul_b = 17'sd21024 - $signed(p14); end
      5'd7: begin mul_a = 21'(zc); mul_b = 17'sd51472 - $signed(p14); end
      5'd8: begin
        mul_a = 21'(w_rad);
        mul_b = ang_c[9] ? -$signed(p15) : $signed(p15);
      end
      5'd9: begin mul_a = 21'(w_rad); mul_b = sin_v; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_TRIG) begin
      prod <= mul_a * mul_b;
      if (cmd.step == 5'd1 || cmd.step == 5'd5) begin
        z2 <= p14[14:0];
      end
      if (cmd.step == 5'd4) begin
        sin_v <= s_now;
      end
      if (cmd.step == 5'd9) begin
        acc_a <= prod;
      end
      if (cmd.step == 5'd10) begin
        acc_b <= prod;
      end
    end
  end

  // One corner coordinate: rotate, round half up, add center, saturate.
  assign ck = cmd.step[2:0];
  always_comb begin
    pa    = ck[1] ? acc_a : -acc_a;
    pb    = ck[2] ? acc_b : -acc_b;
    qa    = ck[1] ? acc_b : -acc_b;
    qb    = ck[2] ? acc_a : -acc_a;
    v     = ck[0] ? (qa + qb) : (pa - pb);
    rnd   = (v + 38'sd2097152) >>> 22;
    ctr   = ck[0] ? w_cy : w_cx;
    tot   = 18'(rnd) + 18'(ctr);
    if (tot > 18'sd32767) begin
      sat_v = 16'sh7fff;
    end else if (tot < -18'sd32768) begin
      sat_v = 16'sh8000;
    end else begin
      sat_v = tot[15:0];
    end
  end

  // Pending result and output register.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_SPAWN) begin
      pend_slot  <= full ? '0 : SLOT_W'(free_idx);
      pend_acc   <= !full;
      pend_alpha <= '0;
      for (int k = 0; k < CORNER_N; k++) begin
        pend_c[k] <= '0;
      end
    end else if (cmd.op == OP_CORNER) begin
      pend_slot  <= SLOT_W'(cmd_idx);
      pend_acc   <= 1'b1;
      pend_alpha <= w_alpha;
      pend_c[ck] <= sat_v;
    end
    if (cmd.op == OP_MOVE) begin
      out_slot  <= pend_slot;
      out_acc   <= pend_acc;
      out_alpha <= pend_alpha;
      out_last  <= cmd.last;
      for (int k = 0; k < CORNER_N; k++) begin
        out_c[k] <= pend_c[k];
      end
    end
  end

  // Pack the result word.
  always_comb begin
    out_data = '0;
    out_data[SLOT_W-1:0] = out_slot;
    for (int k = 0; k < CORNER_N; k++) begin
      out_data[SLOT_W + COORD_W*k +: COORD_W] = out_c[k];
    end
    out_data[SLOT_W + COORD_W*CORNER_N +: ALPHA_W] = out_alpha;
  end

endmodule

// ----- rtl/fspp_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the particle pool: sequences spawn, tick and result hand-off.
// Depends on fspp_pkg.
module fspp_ctrl import fspp_pkg::*; #(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF,
  parameter int IDX_W      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic             s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  dp_stat_t         stat,
  output dp_cmd_t          cmd,
  output logic [IDX_W-1:0] cmd_idx
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_DIV   = 9'b000000010,
    ST_SPAWN = 9'b000000100,
    ST_RD    = 9'b000001000,
    ST_UPD   = 9'b000010000,
    ST_TRIG  = 9'b000100000,
    ST_WAITP = 9'b001000000,
    ST_CORN  = 9'b010000000,
    ST_FLUSH = 9'b100000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             pend_valid, pend_next;
  logic             out_valid, out_next;
  logic             out_free, last_slot;

  assign out_free  = !out_valid || m_tready;
  assign last_slot = (idx == IDX_W'(POOL_SLOTS - 1));
  assign s_tready  = (state == ST_IDLE);
  assign m_tvalid  = out_valid;
  assign cmd_idx   = idx;

  // Next-state and command logic.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    idx_next   = idx;
    pend_next  = pend_valid;
    out_next   = out_valid && !m_tready;
    cmd.op     = OP_NONE;
    cmd.step   = cnt;
    cmd.last   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_ACCEPT;
          cnt_next   = '0;
          idx_next   = '0;
          state_next = s_tuser ? ST_RD : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (cnt == DIV_LAST) begin
          state_next = ST_SPAWN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SPAWN: begin
        cmd.op     = OP_SPAWN;
        pend_next  = 1'b1;
        state_next = ST_FLUSH;
      end
      ST_RD: begin
        if (stat.cur_used) begin
          state_next = ST_UPD;
        end else if (last_slot) begin
          state_next = ST_FLUSH;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_UPD: begin
        cmd.op = OP_UPDATE;
        if (stat.live) begin
          cnt_next   = '0;
          state_next = ST_TRIG;
        end else if (last_slot) begin
          state_next = ST_FLUSH;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_RD;
        end
      end
      ST_TRIG: begin
        cmd.op = OP_TRIG;
        if (cnt == TRIG_LAST) begin
          state_next = ST_WAITP;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_WAITP: begin
        if (!pend_valid) begin
          cnt_next   = '0;
          state_next = ST_CORN;
        end else if (out_free) begin
          cmd.op     = OP_MOVE;
          out_next   = 1'b1;
          pend_next  = 1'b0;
          cnt_next   = '0;
          state_next = ST_CORN;
        end
      end
      ST_CORN: begin
        cmd.op = OP_CORNER;
        if (cnt == CORN_LAST) begin
          pend_next = 1'b1;
          if (last_slot) begin
            state_next = ST_FLUSH;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = ST_RD;
          end
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          cmd.op     = OP_MOVE;
          cmd.last   = 1'b1;
          out_next   = 1'b1;
          pend_next  = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      idx        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      idx        <= idx_next;
      pend_valid <= pend_next;
      out_valid  <= out_next;
    end
  end

endmodule

// ----- rtl/fspp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the particle pool, bound to the top level.
// Depends on fspp_pkg and fading_sprite_particle_pool_top.
module fspp_checker import fspp_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_we,
  input logic [CFG_W-1:0]      cfg_wdata,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser,
  input logic                  m_tlast
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed while stalled");

  // The block works on one command at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a command is in progress");

  // A dropped spawn is a single all-zero word.
  a_reject: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata == '0))
    else $error("rejected spawn word malformed");

  // Configuration data is never unknown when written while the block is idle.
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> !$isunknown(cfg_wdata) || !s_tready)
    else $error("unknown radius written while idle");

endmodule

bind fading_sprite_particle_pool_top fspp_checker u_fspp_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the fading sprite particle pool: spawns and ticks
// are checked word by word against a behavioral pool model. Depends on fspp_pkg.
module tb_top;
  import fspp_pkg::*;

  // Particle state kept by the behavioral model.
  typedef struct {
    bit            used;
    int unsigned   life;
    longint        radius;
    longint        rstep;
    int            alpha;
    int            astep;
    int            cx;
    int            cy;
    int unsigned   angle;
  } particle_t;

  // One expected output word.
  typedef struct {
    logic [SLOT_W-1:0]  slot;
    logic               accepted;
    logic [15:0]        corner [CORNER_N];
    logic [ALPHA_W-1:0] alpha;
    logic               last;
  } quad_word_t;

  // One row of the directed table; has_exp marks a row with a typed result.
  typedef struct {
    bit          mode;
    logic [15:0] px;
    logic [15:0] py;
    logic [9:0]  life;
    logic [9:0]  angle;
    bit          has_exp;
    logic [3:0]  exp_slot;
    logic        exp_acc;
  } stim_row_t;

  localparam int NSLOT = 16;
  localparam int WATCHDOG_LIMIT = 200000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  particle_t  pool [NSLOT];
  int         radius_reg;
  quad_word_t pending_words [$];
  int         error_count;
  int         idle_cycles;
  int         send_idle_pct;
  int         recv_stall_pct;

  fading_sprite_particle_pool_top u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Quarter-wave sine in Q1.14 for q in 0..256.
  function automatic longint quarter_sine(int q);
    longint z;
    longint z2;
    longint t;
    longint u;
    z = q * 64;
    z2 = (z * z) >>> 14;
    t = 21024 - ((z2 * 2320) >>> 14);
    u = 51472 - ((z2 * t) >>> 14);
    return (z * u) >>> 15;
  endfunction

  function automatic longint sine_q14(int unsigned a);
    int unsigned q;
    q = a & 255;
    case ((a & 1023) >> 8)
      0: return quarter_sine(q);
      1: return quarter_sine(256 - q);
      2: return -quarter_sine(q);
      default: return -quarter_sine(256 - q);
    endcase
  endfunction

  // Rounded shift by 22 (ties up), plus center, saturated to 16 bits.
  function automatic logic [15:0] place_coord(longint prod, int center);
    longint v;
    v = ((prod + (longint'(1) << 21)) >>> 22) + center;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Applies one command to the model and queues the words it causes.
  task automatic predict_command(bit mode, logic [15:0] px, logic [15:0] py,
                                 logic [9:0] life_in, logic [9:0] ang);
    quad_word_t w;
    int unsigned lf;
    longint c;
    longint s;
    longint r;
    longint dx;
    longint dy;
    int first_new;
    w.slot = '0;
    w.accepted = 1'b0;
    w.alpha = '0;
    w.last = 1'b1;
    for (int k = 0; k < CORNER_N; k++) w.corner[k] = '0;
    if (!mode) begin
      lf = (life_in == 0) ? 1 : life_in;
      for (int i = 0; i < NSLOT; i++) begin
        if (!pool[i].used) begin
          pool[i].used = 1'b1;
          pool[i].cx = $signed(px);
          pool[i].cy = $signed(py);
          pool[i].life = lf;
          pool[i].angle = ang;
          pool[i].radius = longint'(radius_reg) << 8;
          pool[i].rstep = pool[i].radius / lf;
          pool[i].alpha = 255;
          pool[i].astep = 255 / lf;
          w.slot = SLOT_W'(i);
          w.accepted = 1'b1;
          break;
        end
      end
      pending_words.push_back(w);
      return;
    end
    first_new = pending_words.size();
    for (int i = 0; i < NSLOT; i++) begin
      if (!pool[i].used) continue;
      pool[i].life--;
      pool[i].radius = (pool[i].radius > pool[i].rstep) ?
                       pool[i].radius - pool[i].rstep : 0;
      pool[i].alpha = (pool[i].alpha > pool[i].astep) ?
                      pool[i].alpha - pool[i].astep : 0;
      if (pool[i].life == 0) begin
        pool[i].used = 1'b0;
        continue;
      end
      c = sine_q14((pool[i].angle + 256) & 1023);
      s = sine_q14(pool[i].angle);
      r = pool[i].radius;
      w.slot = SLOT_W'(i);
      w.accepted = 1'b1;
      for (int k = 0; k < 4; k++) begin
        dx = (k % 2 == 0) ? -r : r;
        dy = (k < 2) ? -r : r;
        w.corner[2*k]   = place_coord(dx * c - dy * s, pool[i].cx);
        w.corner[2*k+1] = place_coord(dx * s + dy * c, pool[i].cy);
      end
      w.alpha = ALPHA_W'(pool[i].alpha);
      w.last = 1'b0;
      pending_words.push_back(w);
    end
    if (pending_words.size() > first_new)
      pending_words[pending_words.size()-1].last = 1'b1;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Compares every accepted output word with the oldest expected one.
  always @(posedge clk) begin
    quad_word_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word, slot", m_tdata[3:0], -1);
      end else begin
        w = pending_words.pop_front();
        if (m_tdata[3:0] !== w.slot) report_mismatch("slot", m_tdata[3:0], w.slot);
        if (m_tuser !== w.accepted) report_mismatch("accepted", m_tuser, w.accepted);
        for (int k = 0; k < CORNER_N; k++)
          if (m_tdata[4+16*k +: 16] !== w.corner[k])
            report_mismatch($sformatf("corner coord %0d", k),
                            $signed(m_tdata[4+16*k +: 16]), $signed(w.corner[k]));
        if (m_tdata[139:132] !== w.alpha)
          report_mismatch("fade_alpha", m_tdata[139:132], w.alpha);
        if (m_tlast !== w.last) report_mismatch("last", m_tlast, w.last);
      end
    end
  end

  // Receiver stalls at the rate of the current phase.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Sends one command and runs it through the model once accepted. It is
  // entered at a falling edge and returns at the next falling edge after the
  // handshake, leaving tvalid for the next command or for the caller to drop.
  task automatic send_command(bit mode, logic [15:0] px, logic [15:0] py,
                              logic [9:0] life_in, logic [9:0] ang);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {4'b0, ang, life_in, py, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_command(mode, px, py, life_in, ang);
    @(negedge clk);
  endtask

  // Waits until every expected word has arrived, plus a quiet spell.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_radius(int value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    radius_reg = value;
  endtask

  // Mostly spawns with short lives and ticks so slots are reused often.
  task automatic random_commands(int count);
    bit mode;
    logic [9:0] lf;
    for (int n = 0; n < count; n++) begin
      mode = ($urandom_range(99) < 45);
      lf = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(12));
      send_command(mode, 16'($urandom), 16'($urandom), lf, 10'($urandom));
    end
  endtask

  stim_row_t directed [$];

  function automatic stim_row_t mk(bit mode, int px, int py, int lf, int ang,
                                   bit he, int es, bit ea);
    stim_row_t r;
    r.mode = mode; r.px = 16'(px); r.py = 16'(py); r.life = 10'(lf);
    r.angle = 10'(ang);
    r.has_exp = he; r.exp_slot = 4'(es); r.exp_acc = ea;
    return r;
  endfunction

  initial begin
    int radii [4];
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    idle_cycles = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b1;
    radius_reg = 256;
    for (int i = 0; i < NSLOT; i++) pool[i].used = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty tick, zero life, field extremes, full pool, expiry.
    directed.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(0, 0, 0, 0, 0, 1, 0, 1));
    directed.push_back(mk(0, 32767, 32767, 1023, 1023, 1, 1, 1));
    directed.push_back(mk(0, -32768, -32768, 1, 256, 1, 2, 1));
    directed.push_back(mk(0, 100, -100, 3, 128, 1, 3, 1));
    directed.push_back(mk(0, 16'hAAAA, 16'h5555, 10'h2AA, 10'h155, 1, 4, 1));
    directed.push_back(mk(0, 16'h5555, 16'hAAAA, 10'h155, 10'h2AA, 1, 5, 1));
    for (int i = 6; i < NSLOT; i++)
      directed.push_back(mk(0, i * 300, -i * 200, 4 + i, i * 64, 1, i, 1));
    directed.push_back(mk(0, 1, 1, 5, 5, 1, 0, 0));
    directed.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(0, 7, 7, 2, 768, 0, 0, 0));
    foreach (directed[i]) begin
      send_command(directed[i].mode, directed[i].px, directed[i].py,
                   directed[i].life, directed[i].angle);
      if (directed[i].has_exp) begin
        if (pending_words[pending_words.size()-1].slot !== directed[i].exp_slot ||
            pending_words[pending_words.size()-1].accepted !== directed[i].exp_acc)
          report_mismatch("directed spawn table row", i, -1);
      end
    end
    // Sender holds off until everything has come back.
    drain_results();
    repeat (3) send_command(1, 0, 0, 0, 0);

    // Random phases over several radius settings and idle mixes.
    radii = '{0, 4095, 1, 1000};
    for (int ph = 0; ph < 4; ph++) begin
      write_radius(radii[ph]);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      random_commands(40);
      repeat (20) send_command(1, 0, 0, 0, 0);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_results();
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
